// ----- rtl/pss_pkg.sv -----
// Shared types, constants and codes of the priority stream selector.
package pss_pkg;

  localparam int ZONES = 16;
  localparam int ZW    = (ZONES > 1) ? $clog2(ZONES) : 1;

  localparam logic [4:0]  NO_ZONE    = 5'd16;
  localparam logic [11:0] MIN_PACKET = 12'd12;

  localparam logic [15:0] RST_SILENCE    = 16'd500;
  localparam logic [4:0]  RST_ZONE_COUNT = 5'd16;
  localparam logic [63:0] RST_PRIO       = 64'd0;
  localparam logic [31:0] RST_SSRC       = 32'h5A5A_0001;
  localparam logic [15:0] RST_TS_STEP    = 16'd160;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SILENCE    = 3'd0,
    CFG_ZONE_COUNT = 3'd1,
    CFG_PRIO       = 3'd2,
    CFG_SSRC       = 3'd3,
    CFG_TS_STEP    = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic          found;
    logic [ZW-1:0] idx;
    logic [3:0]    prio;
  } scan_t;

  typedef struct packed {
    logic        upd;
    logic        sweep;
    logic        hit;
    logic [3:0]  zone;
    logic [31:0] now;
    logic [15:0] limit;
    logic [4:0]  used;
  } cell_ctl_t;

endpackage

// ----- rtl/priority_stream_selector_rtp_rewrite.sv -----
// Top level: request register, control sequencer, zone cell chain, header rewrite.
// A request is taken only in idle; it then runs an update step, the winner scan
// that moves one cell per cycle along the zone chain, and a finish step that
// waits for a free output register. Only then is the next request taken.
// A finished result waits in the output register while the next request is taken.
// Reset: all zones inactive, no current zone, counters zero, registers at defaults.
module priority_stream_selector_rtp_rewrite import pss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // zone, now_ms, packet_length, payload_type
  input  logic                  s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // marker, out_payload_type, seq_number,
                                               // rtp_timestamp, ssrc_value,
                                               // current_zone_out, released
  output logic                  m_axis_tuser,  // forwarded
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [15:0] silence_q;
  logic [4:0]  zone_count_q;
  logic [63:0] prio_q;
  logic [31:0] ssrc_q;
  logic [15:0] ts_step_q;

  logic        func_q;
  logic [3:0]  zone_q;
  logic [31:0] now_q;
  logic [11:0] len_q;
  logic [6:0]  pt_q;

  state_e        state_q, state_d;
  logic [ZW-1:0] cnt_q, cnt_d;
  logic [4:0]    cur_q, cur_d;
  logic [15:0]   seq_q, seq_d;
  logic [31:0]   ts_q, ts_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic                  out_fwd_q, out_fwd_d;

  logic        accept;
  logic        upd, sweep, fin;
  logic [4:0]  used;
  logic        hit;
  logic        fwd, mark, rel, out_free;
  logic [4:0]  cur_mid, cur_fin;
  cell_ctl_t   ctl;
  scan_t       chain [ZONES+1];
  logic [ZONES-1:0] expire;
  scan_t       win;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q    <= RST_SILENCE;
      zone_count_q <= RST_ZONE_COUNT;
      prio_q       <= RST_PRIO;
      ssrc_q       <= RST_SSRC;
      ts_step_q    <= RST_TS_STEP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SILENCE:    silence_q    <= cfg_data_i[15:0];
        CFG_ZONE_COUNT: zone_count_q <= cfg_data_i[4:0];
        CFG_PRIO:       prio_q       <= cfg_data_i;
        CFG_SSRC:       ssrc_q       <= cfg_data_i[31:0];
        CFG_TS_STEP:    ts_step_q    <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= s_axis_tuser;
      zone_q <= s_axis_tdata[3:0];
      now_q  <= s_axis_tdata[35:4];
      len_q  <= s_axis_tdata[47:36];
      pt_q   <= s_axis_tdata[54:48];
    end
  end

  assign used = (zone_count_q > 5'(ZONES)) ? 5'(ZONES) : zone_count_q;
  assign hit  = !func_q && (len_q >= MIN_PACKET) && ({1'b0, zone_q} < used);

  always_comb begin
    ctl.upd   = upd;
    ctl.sweep = sweep;
    ctl.hit   = hit;
    ctl.zone  = zone_q;
    ctl.now   = now_q;
    ctl.limit = silence_q;
    ctl.used  = used;
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < ZONES; g++) begin : g_cell
    pss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (ZW'(g)),
      .ctl_i      (ctl),
      .prio_i     (prio_q[4*g +: 4]),
      .carry_i    (chain[g]),
      .carry_o    (chain[g+1]),
      .expire_o   (expire[g])
    );
  end

  assign win = chain[ZONES];

  always_comb begin
    out_free = !out_valid_q || m_axis_tready;
    fwd      = hit && win.found && (4'(win.idx) == zone_q);
    mark     = (cur_q != {1'b0, zone_q});
    cur_mid  = fwd ? {1'b0, zone_q} : cur_q;
    rel      = (cur_mid != NO_ZONE) && expire[cur_mid[ZW-1:0]];
    cur_fin  = rel ? NO_ZONE : cur_mid;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    upd     = 1'b0;
    sweep   = 1'b0;
    fin     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        upd     = 1'b1;
        cnt_d   = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ZW'(ZONES - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          sweep   = 1'b1;
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    seq_d       = seq_q;
    ts_d        = ts_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_fwd_d   = out_fwd_q;
    if (fin) begin
      cur_d       = cur_fin;
      out_valid_d = 1'b1;
      out_fwd_d   = fwd;
      if (fwd) begin
        seq_d      = seq_q + 16'd1;
        ts_d       = ts_q + {16'd0, ts_step_q};
        out_data_d = {2'b00, rel, cur_fin, ssrc_q, ts_q, seq_q, pt_q, mark};
      end else begin
        out_data_d = {2'b00, rel, cur_fin, 88'd0};
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      cur_q       <= NO_ZONE;
      seq_q       <= '0;
      ts_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      seq_q       <= seq_d;
      ts_q        <= ts_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_fwd_q  <= out_fwd_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_fwd_q;

endmodule

// ----- rtl/pss_cell.sv -----
// One zone cell: activity and last-arrival time, one step of the winner scan.
module pss_cell import pss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [ZW-1:0] cell_idx_i,
  input  cell_ctl_t     ctl_i,
  input  logic [3:0]    prio_i,
  input  scan_t         carry_i,
  output scan_t         carry_o,
  output logic          expire_o
);

  logic        active_q, active_d;
  logic [31:0] last_q, last_d;
  scan_t       carry_q, carry_d;
  logic [31:0] elapsed;
  logic        in_use;
  logic        take;

  always_comb begin
    elapsed  = ctl_i.now - last_q;
    expire_o = active_q && (elapsed > {16'd0, ctl_i.limit});
    in_use   = 5'(cell_idx_i) < ctl_i.used;
    take     = active_q && in_use && (!carry_i.found || (prio_i < carry_i.prio));

    active_d = active_q;
    last_d   = last_q;
    if (ctl_i.upd && ctl_i.hit && (ctl_i.zone == 4'(cell_idx_i))) begin
      active_d = 1'b1;
      last_d   = ctl_i.now;
    end else if (ctl_i.sweep && expire_o) begin
      active_d = 1'b0;
    end

    if (take) begin
      carry_d = '{found: 1'b1, idx: cell_idx_i, prio: prio_i};
    end else begin
      carry_d = carry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      last_q   <= '0;
      carry_q  <= '0;
    end else begin
      active_q <= active_d;
      last_q   <= last_d;
      carry_q  <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

// ----- rtl/pss_checker.sv -----
// Port-level checks of the priority stream selector, bound to the top level.
module pss_checker import pss_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while previous one still in work");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_idle_header_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[87:0] == 88'd0)
    else $error("header fields set on a dropped request");

  a_release_clears_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[93] |-> m_axis_tdata[92:88] == NO_ZONE)
    else $error("current zone kept after release");

endmodule

bind priority_stream_selector_rtp_rewrite pss_checker u_pss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
